>>> hdl/sidt_pkg.sv
// shared types and constants for the signed integer to decimal text converter
package sidt_pkg;

  localparam int DATA_W     = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int COUNT_W    = 5;
  localparam int IDX_W      = 4;
  localparam int CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP,
    ST_DIGITS
  } sidt_state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic prep;
    logic emit_sign;
    logic emit_digit;
  } sidt_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic neg;
    logic digit_last;
  } sidt_status_t;

endpackage

>>> hdl/sidt_datapath.sv
// datapath: magnitude shift register, bcd digits, output character registers
module sidt_datapath import sidt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [DATA_W-1:0] in_value,
  input  sidt_cmd_t                cmd,
  output sidt_status_t             status,
  output logic                     out_valid,
  output logic [CHAR_W-1:0]        out_character,
  output logic                     out_last_char
);

  logic [DATA_W-1:0]  bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [BCD_W-1:0]   bcd_adj;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   top_idx;
  logic               neg_r, neg_nxt;
  logic               valid_r, valid_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;
  logic               last_r, last_nxt;
  logic [DATA_W-1:0]  raw;
  logic [3:0]         cur_digit;

  assign raw = DATA_W'(in_value);

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // highest nonzero digit, zero gives digit 0
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd_r[4*idx_r +: 4];

  // next values
  always_comb begin
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    neg_nxt   = neg_r;
    valid_nxt = 1'b0;
    char_nxt  = char_r;
    last_nxt  = last_r;
    if (cmd.load) begin
      neg_nxt = raw[DATA_W-1];
      bin_nxt = raw[DATA_W-1] ? (DATA_W'(0) - raw) : raw;
      bcd_nxt = '0;
      cnt_nxt = '0;
    end
    if (cmd.shift) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[DATA_W-1]};
      bin_nxt = {bin_r[DATA_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.prep) begin
      idx_nxt = top_idx;
    end
    if (cmd.emit_sign) begin
      valid_nxt = 1'b1;
      char_nxt  = CHAR_MINUS;
      last_nxt  = 1'b0;
    end
    if (cmd.emit_digit) begin
      valid_nxt = 1'b1;
      char_nxt  = CHAR_ZERO + CHAR_W'(cur_digit);
      last_nxt  = (idx_r == '0);
      idx_nxt   = idx_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  // status to the controller
  assign status.conv_last  = (cnt_r == COUNT_W'(DATA_W - 1));
  assign status.neg        = neg_r;
  assign status.digit_last = (idx_r == '0);

  assign out_valid     = valid_r;
  assign out_character = char_r;
  assign out_last_char = last_r;

endmodule

>>> hdl/sidt_ctrl.sv
// controller: sequences load, conversion, sign and digit output
module sidt_ctrl import sidt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  sidt_status_t status,
  output sidt_cmd_t    cmd,
  output logic         busy
);

  sidt_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (status.conv_last) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep      = 1'b1;
        cmd.emit_sign = status.neg;
        state_nxt     = ST_DIGITS;
      end
      ST_DIGITS: begin
        cmd.emit_digit = 1'b1;
        if (status.digit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/signed_int_to_decimal_text.sv
// top level: signed 32-bit integer to decimal ascii text
//
//  channel   ports                                    handshake
//  request   start, busy, in_value                    taken when start & !busy
//  result    out_valid, out_character, out_last_char  one-cycle strobe, no stall
//
// one request: a load step, a shift-and-add-3 step for each of the 32 magnitude bits,
// a step that emits the sign if negative, then one digit per cycle (1 to 10 digits).
// each character is registered and leaves its register in the cycle after it is formed.
// reset is synchronous, active low, and returns the controller to idle.
// the receiver cannot stall; results are strobed out as they are made.
module signed_int_to_decimal_text import sidt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic [CHAR_W-1:0]        out_character,
  output logic                     out_last_char
);

  sidt_cmd_t    cmd;
  sidt_status_t status;

  // control sequencer
  sidt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // conversion datapath
  sidt_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last_char (out_last_char)
  );

endmodule
